### design/sact_pkg.sv
// Shared types and constants for the set-associative tag array with recency order.
// Depends on nothing; used by every module under design/.
`timescale 1ns / 1ps
package sact_pkg;
  localparam int NUM_SETS  = 64;
  localparam int NUM_WAYS  = 8;
  localparam int ADDR_BITS = 32;
  localparam int SET_BITS  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int TAG_BITS  = ADDR_BITS - $clog2(NUM_SETS);
  localparam int RANK_BITS = $clog2(NUM_WAYS) + 1;
  localparam int QDEPTH    = 2;

  typedef enum logic [2:0] {
    K_LOOKUP = 3'd0, K_TOUCH = 3'd1, K_FILL = 3'd2, K_INVAL = 3'd3, K_SETST = 3'd4
  } kind_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] address;
    logic [2:0]  way_in;
    logic [2:0]  coh_in;
    logic [7:0]  busy_ways;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  way_out;
    logic [2:0]  line_state;
    logic        victim_valid;
    logic [31:0] victim_address;
    logic [2:0]  victim_state;
    logic        order_error;
  } rsp_t;

  // Classified command handed from front to back.
  typedef struct packed {
    kind_t                 kind;
    logic                  way_ok;
    logic [SET_BITS-1:0]   set;
    logic [TAG_BITS-1:0]   tag;
    logic [2:0]            way;
    logic [2:0]            nst;
    logic [NUM_WAYS-1:0]   busy;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic [TAG_BITS-1:0] tag;
    logic [2:0] coh;
    logic [RANK_BITS-1:0] rank;
  } entry_t;

  typedef enum logic [1:0] {B_IDLE, B_READ, B_EXEC} bstate_t;
endpackage

### design/set_assoc_cache_tags_lru_busy_skip_unit.sv
// Each command goes from the queue through the back end states: pop in idle, row read,
// execute and write; the result strobe is registered after execute, and the back end takes
// the next command only once it is back in idle. A two-entry queue takes commands while the
// back end works; busy marks it full. Synchronous reset; afterwards a clearing pass runs
// through every set (NUM_SETS = 64) of the row memory, during which queued commands wait. Results cannot be stalled.
`timescale 1ns / 1ps
module set_assoc_cache_tags_lru_busy_skip_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  sact_pkg::req_t req,
  output logic           busy,
  output logic           done,
  output sact_pkg::rsp_t result
);
  logic q_valid, q_pop;
  sact_pkg::cmd_t q_cmd;

  sact_front u_front (.clk, .rst, .start, .req, .busy, .q_valid, .q_cmd, .q_pop);
  sact_back  u_back  (.clk, .rst, .q_valid, .q_cmd, .q_pop, .done, .result);
endmodule

### design/sact_front.sv
// Front end: accepts commands, classifies them and queues them for the back end.
// Depends on sact_pkg.
`timescale 1ns / 1ps
module sact_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  sact_pkg::req_t  req,
  output logic            busy,
  output logic            q_valid,
  output sact_pkg::cmd_t  q_cmd,
  input  logic            q_pop
);
  sact_pkg::cmd_t q [sact_pkg::QDEPTH];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic push;
  sact_pkg::cmd_t cls;
  logic [31:0] addr;

  // Classify: split address, check the way, mask busy bits.
  always_comb begin
    addr = req.address & (32'hFFFF_FFFF >> (32 - sact_pkg::ADDR_BITS));
    cls.kind = sact_pkg::kind_t'(req.kind);
    cls.way_ok = ({29'd0, req.way_in} < 32'(sact_pkg::NUM_WAYS));
    cls.set = sact_pkg::SET_BITS'(addr % sact_pkg::NUM_SETS);
    cls.tag = sact_pkg::TAG_BITS'(addr >> $clog2(sact_pkg::NUM_SETS));
    cls.way = req.way_in;
    cls.nst = req.coh_in;
    cls.busy = sact_pkg::NUM_WAYS'(req.busy_ways);
  end

  assign busy = (count == 2'(sact_pkg::QDEPTH));
  assign push = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_cmd = q[rd_ptr];

  // Advance the queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0; wr_ptr <= 1'b0; count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
  end
endmodule

### design/sact_back.sv
// Back end: reads one set, decides the outcome and writes the set back when the command changes it.
// Depends on sact_pkg.
`timescale 1ns / 1ps
module sact_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  sact_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           done,
  output sact_pkg::rsp_t result
);
  localparam int NW = sact_pkg::NUM_WAYS;
  localparam int RB = sact_pkg::RANK_BITS;
  localparam logic [RB-1:0] ABSENT = {RB{1'b1}};
  localparam int SB = sact_pkg::SET_BITS;

  // One row per set: all ways side by side.
  sact_pkg::entry_t mem [sact_pkg::NUM_SETS][NW];
  sact_pkg::entry_t row [NW];
  sact_pkg::entry_t row_next [NW];
  logic             we;
  logic [SB:0]      clr;
  sact_pkg::bstate_t state, state_next;
  sact_pkg::cmd_t   cmd;
  sact_pkg::rsp_t   rsp;

  // Clearing pass after reset, then idle/read/execute.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sact_pkg::B_IDLE;
      clr <= '0;
    end else begin
      state <= state_next;
      if (!clr[SB]) clr <= clr + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    case (state)
      sact_pkg::B_IDLE: if (q_valid && clr[SB]) begin
        q_pop = 1'b1; state_next = sact_pkg::B_READ;
      end
      sact_pkg::B_READ: state_next = sact_pkg::B_EXEC;
      sact_pkg::B_EXEC: state_next = sact_pkg::B_IDLE;
      default: state_next = sact_pkg::B_IDLE;
    endcase
  end

  // Latch the command, clear or write back rows, then read its row once the set is known.
  always_ff @(posedge clk) begin
    if (q_pop) cmd <= q_cmd;
    for (int w = 0; w < NW; w++) begin
      if (!clr[SB])
        mem[clr[SB-1:0]][w] <= '{valid: 1'b0, tag: '0, coh: 3'd0, rank: ABSENT};
      else if (we) mem[cmd.set][w] <= row_next[w];
      if (state == sact_pkg::B_READ) row[w] <= mem[cmd.set][w];
    end
  end

  // Execute the command on the row.
  always_comb begin
    logic found, tfound;
    logic [RB-1:0] cnt, r, rr;
    logic [3:0] tgt;
    logic [RB-1:0] rk;
    rsp = '0;
    we = 1'b0;
    found = 1'b0; tfound = 1'b0; cnt = '0; tgt = '0; rk = '0; r = '0; rr = '0;
    for (int w = 0; w < NW; w++) row_next[w] = row[w];
    case (cmd.kind)
      sact_pkg::K_LOOKUP: begin
        for (int w = NW - 1; w >= 0; w--)
          if (row[w].valid && row[w].tag == cmd.tag) begin
            rsp.hit = 1'b1; rsp.way_out = 3'(w); rsp.line_state = row[w].coh;
          end
      end
      sact_pkg::K_TOUCH: if (cmd.way_ok) begin
        we = 1'b1;
        rk = row[cmd.way].rank;
        for (int w = 0; w < NW; w++)
          if (row[w].rank != ABSENT && 3'(w) != cmd.way &&
              (rk == ABSENT || row[w].rank < rk))
            row_next[w].rank = row[w].rank + 1'b1;
        row_next[cmd.way].rank = '0;
      end
      sact_pkg::K_FILL: begin
        for (int w = NW - 1; w >= 0; w--)
          if (!row[w].valid) begin found = 1'b1; tgt = 4'(w); end
        if (!found) begin
          for (int w = 0; w < NW; w++)
            if (row[w].rank != ABSENT) cnt = cnt + 1'b1;
          if (cnt == '0) rsp.order_error = 1'b1;
          else begin
            // Default to LRU way, then scan non-busy from LRU toward rank 1.
            for (int w = 0; w < NW; w++)
              if (row[w].rank == cnt - 1'b1) tgt = 4'(w);
            for (int w = 0; w < NW; w++)
              if (row[w].rank != ABSENT && !cmd.busy[w] &&
                  (row[w].rank != '0 || cnt == RB'(1)) &&
                  (!tfound || row[w].rank > rr)) begin
                tfound = 1'b1; rr = row[w].rank; r = RB'(w);
              end
            if (tfound) tgt = 4'(r);
            found = 1'b1;
            rsp.victim_valid = 1'b1;
            rsp.victim_address = 32'({row[tgt[2:0]].tag, cmd.set});
            rsp.victim_state = row[tgt[2:0]].coh;
          end
        end
        if (found) begin
          we = 1'b1;
          row_next[tgt[2:0]].valid = 1'b1;
          row_next[tgt[2:0]].tag = cmd.tag;
          row_next[tgt[2:0]].coh = cmd.nst;
          rsp.way_out = tgt[2:0];
        end
      end
      sact_pkg::K_INVAL: if (cmd.way_ok) begin
        we = 1'b1;
        row_next[cmd.way].valid = 1'b0;
        row_next[cmd.way].coh = 3'd0;
      end
      sact_pkg::K_SETST: if (cmd.way_ok) begin
        we = 1'b1;
        row_next[cmd.way].coh = cmd.nst;
      end
      default: we = 1'b0;
    endcase
    if (state != sact_pkg::B_EXEC) we = 1'b0;
  end

  // Register the result beat.
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= (state == sact_pkg::B_EXEC);
    result <= rsp;
  end
endmodule

### tb/tb_set_assoc_cache_tags_lru_busy_skip_unit.sv
// Testbench for the set-associative tag array with recency order and busy-way skip.
// Depends on sact_pkg and set_assoc_cache_tags_lru_busy_skip_unit; a built-in predictor
// works out each expected response, which is checked against every done beat.
`timescale 1ns / 1ps
module tb_set_assoc_cache_tags_lru_busy_skip_unit;
  localparam int ABSENT = 255;
  localparam int STALL_LIMIT = 4000;
  localparam int NSETS = sact_pkg::NUM_SETS;
  localparam int NWAYS = sact_pkg::NUM_WAYS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  sact_pkg::req_t req = '0;
  logic busy;
  logic done;
  sact_pkg::rsp_t result;

  set_assoc_cache_tags_lru_busy_skip_unit uut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the tag array
  bit          pv_valid [NSETS][NWAYS];
  bit [25:0]   pv_tag   [NSETS][NWAYS];
  bit [2:0]    pv_coh   [NSETS][NWAYS];
  int          pv_rank  [NSETS][NWAYS];

  sact_pkg::rsp_t expected_rsp[$];
  int   errors = 0;
  int   stall_cycles = 0;
  bit   gaps_on = 1'b1;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic int rank_holder(int s, int r);
    for (int w = 0; w < NWAYS; w++)
      if (pv_rank[s][w] == r) return w;
    return -1;
  endfunction

  // Work out the response of one command and update the model state
  function automatic sact_pkg::rsp_t predict_access(sact_pkg::req_t c);
    sact_pkg::rsp_t o;
    int s, tgt, cnt, r, stop, cand, rk;
    bit [25:0] tg;
    o = '0;
    s = int'(c.address % NSETS);
    tg = 26'(c.address / NSETS);
    case (c.kind)
      sact_pkg::K_LOOKUP: begin
        for (int w = 0; w < NWAYS; w++)
          if (pv_valid[s][w] && pv_tag[s][w] == tg) begin
            o.hit = 1'b1; o.way_out = 3'(w); o.line_state = pv_coh[s][w];
            break;
          end
      end
      sact_pkg::K_TOUCH: begin
        rk = pv_rank[s][c.way_in];
        for (int w = 0; w < NWAYS; w++)
          if (pv_rank[s][w] != ABSENT && w != c.way_in && (rk == ABSENT || pv_rank[s][w] < rk))
            pv_rank[s][w]++;
        pv_rank[s][c.way_in] = 0;
      end
      sact_pkg::K_FILL: begin
        tgt = -1;
        for (int w = 0; w < NWAYS; w++)
          if (!pv_valid[s][w]) begin tgt = w; break; end
        if (tgt < 0) begin
          cnt = 0;
          for (int w = 0; w < NWAYS; w++) if (pv_rank[s][w] != ABSENT) cnt++;
          if (cnt == 0) begin
            o.order_error = 1'b1;
            return o;
          end
          r = cnt - 1;
          stop = (cnt == 1) ? 0 : 1;
          tgt = rank_holder(s, cnt - 1);
          forever begin
            cand = rank_holder(s, r);
            if (cand >= 0 && !c.busy_ways[cand]) begin tgt = cand; break; end
            if (r == stop) break;
            r--;
          end
          if (tgt < 0) begin
            o.order_error = 1'b1;
            return o;
          end
          o.victim_valid = 1'b1;
          o.victim_address = {pv_tag[s][tgt], 6'(s)};
          o.victim_state = pv_coh[s][tgt];
        end
        pv_valid[s][tgt] = 1'b1; pv_tag[s][tgt] = tg; pv_coh[s][tgt] = c.coh_in;
        o.way_out = 3'(tgt);
      end
      sact_pkg::K_INVAL: begin
        pv_valid[s][c.way_in] = 1'b0; pv_coh[s][c.way_in] = '0; pv_tag[s][c.way_in] = '0;
      end
      sact_pkg::K_SETST: pv_coh[s][c.way_in] = c.coh_in;
      default: ;
    endcase
    return o;
  endfunction

  // Send one command beat, with an optional random gap ahead of it
  task automatic send_access(input sact_pkg::req_t c);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start <= 1'b1;
    req <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_rsp.push_back(predict_access(c));
  endtask

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    sact_pkg::rsp_t w;
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, 32'd0);
      end else begin
        w = expected_rsp.pop_front();
        if (result.hit != w.hit) report_mismatch("hit", 32'(result.hit), 32'(w.hit));
        if (result.way_out != w.way_out)
          report_mismatch("way_out", 32'(result.way_out), 32'(w.way_out));
        if (result.line_state != w.line_state)
          report_mismatch("line_state", 32'(result.line_state), 32'(w.line_state));
        if (result.victim_valid != w.victim_valid)
          report_mismatch("victim_valid", 32'(result.victim_valid), 32'(w.victim_valid));
        if (result.victim_address != w.victim_address)
          report_mismatch("victim_address", result.victim_address, w.victim_address);
        if (result.victim_state != w.victim_state)
          report_mismatch("victim_state", 32'(result.victim_state), 32'(w.victim_state));
        if (result.order_error != w.order_error)
          report_mismatch("order_error", 32'(result.order_error), 32'(w.order_error));
      end
    end
  end

  // Watchdog: count cycles with no beat accepted either way
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("set_assoc_cache_tags_lru_busy_skip_unit: mismatch");
      $finish;
    end
  end

  function automatic sact_pkg::req_t make_access(sact_pkg::kind_t k, logic [31:0] a,
                                                 logic [2:0] w, logic [2:0] st,
                                                 logic [7:0] b);
    sact_pkg::req_t c;
    c.kind = k; c.address = a; c.way_in = w; c.coh_in = st; c.busy_ways = b;
    return c;
  endfunction

  function automatic sact_pkg::req_t random_access(int nsets, int ntags);
    logic [31:0] a;
    logic [2:0] k;
    int pick;
    a = {26'($urandom_range(0, ntags - 1)), 6'($urandom_range(0, nsets - 1))};
    if ($urandom_range(0, 15) == 0) a = $urandom();
    pick = int'($urandom_range(0, 9));
    if (pick > 4) k = (pick > 7) ? sact_pkg::K_TOUCH : sact_pkg::K_FILL;
    else k = 3'(pick);
    if ($urandom_range(0, 40) == 0) k = 3'($urandom_range(5, 7));
    return make_access(sact_pkg::kind_t'(k), a, 3'($urandom()), 3'($urandom()),
                       8'($urandom()));
  endfunction

  // Extreme fields, every kind, unknown kinds, empty order and single-entry order
  task automatic test_directed();
    // Fill set 0 completely with no order: the ninth fill hits the empty-order error
    for (int i = 0; i < 8; i++)
      send_access(make_access(sact_pkg::K_FILL, {26'(i), 6'd0}, 3'd0, 3'(i), 8'h00));
    send_access(make_access(sact_pkg::K_FILL, 32'hFFFF_FFC0, 3'd0, 3'd7, 8'hFF));
    // One way in the order: it is the victim though busy
    send_access(make_access(sact_pkg::K_TOUCH, 32'd0, 3'd5, 3'd0, 8'h00));
    send_access(make_access(sact_pkg::K_FILL, 32'hFFFF_FFC0, 3'd0, 3'd7, 8'hFF));
    send_access(make_access(sact_pkg::K_LOOKUP, 32'hFFFF_FFC0, 3'd0, 3'd0, 8'h00));
    send_access(make_access(sact_pkg::K_TOUCH, 32'd0, 3'd2, 3'd0, 8'h00));
    send_access(make_access(sact_pkg::K_TOUCH, 32'd0, 3'd7, 3'd0, 8'h00));
    send_access(make_access(sact_pkg::K_FILL, 32'h1234_5640, 3'd0, 3'd3, 8'hA4));
    send_access(make_access(sact_pkg::K_FILL, 32'h1234_5680, 3'd0, 3'd3, 8'h00));
    send_access(make_access(sact_pkg::K_SETST, 32'd0, 3'd7, 3'd6, 8'h00));
    send_access(make_access(sact_pkg::K_SETST, 32'h0000_003F, 3'd3, 3'd5, 8'h00));
    send_access(make_access(sact_pkg::K_INVAL, 32'd0, 3'd2, 3'd0, 8'h00));
    send_access(make_access(sact_pkg::K_LOOKUP, 32'h1234_5640, 3'd0, 3'd0, 8'h00));
    send_access(make_access(sact_pkg::K_FILL, 32'hFFFF_FFFF, 3'd7, 3'd7, 8'hFF));
    send_access(make_access(sact_pkg::K_LOOKUP, 32'hFFFF_FFFF, 3'd7, 3'd7, 8'hFF));
    send_access(make_access(sact_pkg::kind_t'(3'd5), 32'hFFFF_FFFF, 3'd7, 3'd7, 8'hFF));
    send_access(make_access(sact_pkg::kind_t'(3'd7), 32'd0, 3'd0, 3'd0, 8'h00));
  endtask

  // Random traffic over nsets sets and ntags tags; small counts make sets fill and evict often
  task automatic test_random(int n, int nsets, int ntags);
    for (int i = 0; i < n; i++) send_access(random_access(nsets, ntags));
  endtask

  // Drop start and hold until every expected result has come
  task automatic drain_results();
    start <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
  endtask

  initial begin
    for (int s = 0; s < NSETS; s++)
      for (int w = 0; w < NWAYS; w++) begin
        pv_valid[s][w] = 0; pv_tag[s][w] = 0; pv_coh[s][w] = 0; pv_rank[s][w] = ABSENT;
      end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    drain_results();
    test_random(700, 4, 12);
    drain_results();
    test_random(500, 64, 4);
    gaps_on = 1'b0;
    test_random(600, 2, 20);
    drain_results();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("set_assoc_cache_tags_lru_busy_skip_unit: match");
    else $display("set_assoc_cache_tags_lru_busy_skip_unit: mismatch");
    $finish;
  end
endmodule

### filelist.f
design/sact_pkg.sv
design/sact_front.sv
design/sact_back.sv
design/set_assoc_cache_tags_lru_busy_skip_unit.sv
tb/tb_set_assoc_cache_tags_lru_busy_skip_unit.sv
